// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/itp_pkg.sv -----
`default_nettype none

package itp_pkg;

    localparam int IPC_STACK_DEPTH = 32;

    // request kinds
    localparam logic [2:0] REQ_NUM    = 3'd0;
    localparam logic [2:0] REQ_LPAREN = 3'd1;
    localparam logic [2:0] REQ_RPAREN = 3'd2;
    localparam logic [2:0] REQ_OP     = 3'd3;
    localparam logic [2:0] REQ_END    = 3'd4;

    // operator codes, left paren shares the stack encoding
    localparam logic [2:0] OP_MUL      = 3'd0;
    localparam logic [2:0] OP_DIV      = 3'd1;
    localparam logic [2:0] OP_MOD      = 3'd2;
    localparam logic [2:0] OP_ADD      = 3'd3;
    localparam logic [2:0] OP_SUB      = 3'd4;
    localparam logic [2:0] LPAREN_MARK = 3'd5;

    typedef enum logic [1:0] {
        KIND_NUM    = 2'd0,
        KIND_OP     = 2'd1,
        KIND_STATUS = 2'd2
    } t_out_kind;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP,
        ST_RD,
        ST_EVAL,
        ST_PUSH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic pop;
        logic emit;
        logic push;
        logic finish;
        logic err_wr;
        t_err err_val;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       op_ok;
        logic       level_zero;
        logic       level_one;
        logic       full;
        logic       top_is_lp;
        logic       top_lower;
        logic       out_free;
        logic       pend_valid;
    } t_stat;

    // multiplicative group has the higher precedence
    function automatic logic is_mul(input logic [2:0] code);
        return code <= OP_MOD;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/itp_ctrl.sv -----
`default_nettype none

module itp_ctrl
    import itp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_stat stat,
    output t_cmd       cmd
);

`include "assert_macros.svh"

    t_state r_state;
    t_state n_state;
    logic   emit_ok;

    assign emit_ok = !stat.pend_valid || stat.out_free;
    assign o_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_DISP;
            end
            ST_DISP: begin
                case (stat.kind)
                    REQ_NUM:    n_state = ST_FINISH;
                    REQ_LPAREN: n_state = ST_PUSH;
                    REQ_RPAREN: n_state = stat.level_zero ? ST_FINISH : ST_RD;
                    REQ_OP: begin
                        if (!stat.op_ok)          n_state = ST_FINISH;
                        else if (stat.level_zero) n_state = ST_PUSH;
                        else                      n_state = ST_RD;
                    end
                    REQ_END:    n_state = stat.level_zero ? ST_FINISH : ST_RD;
                    default:    n_state = ST_FINISH;
                endcase
            end
            ST_RD: n_state = ST_EVAL;
            ST_EVAL: begin
                case (stat.kind)
                    REQ_RPAREN: begin
                        if (stat.top_is_lp) n_state = ST_FINISH;
                        else if (emit_ok)   n_state = stat.level_one ? ST_FINISH : ST_RD;
                    end
                    REQ_OP: begin
                        if (stat.top_is_lp || stat.top_lower) n_state = ST_PUSH;
                        else if (emit_ok) n_state = stat.level_one ? ST_PUSH : ST_RD;
                    end
                    REQ_END: begin
                        if (stat.top_is_lp || emit_ok) begin
                            n_state = stat.level_one ? ST_FINISH : ST_RD;
                        end
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_PUSH: n_state = ST_FINISH;
            ST_FINISH: begin
                if (stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        cmd.err_val = ERR_OK;
        case (r_state)
            ST_IDLE: cmd.load = i_valid;
            ST_DISP: begin
                if (stat.kind == REQ_RPAREN && stat.level_zero) begin
                    cmd.err_wr  = 1'b1;
                    cmd.err_val = ERR_UNMATCHED;
                end
            end
            ST_EVAL: begin
                case (stat.kind)
                    REQ_RPAREN: begin
                        if (stat.top_is_lp) begin
                            cmd.pop = 1'b1;
                        end else if (emit_ok) begin
                            cmd.pop  = 1'b1;
                            cmd.emit = 1'b1;
                            if (stat.level_one) begin
                                cmd.err_wr  = 1'b1;
                                cmd.err_val = ERR_UNMATCHED;
                            end
                        end
                    end
                    REQ_OP: begin
                        if (!(stat.top_is_lp || stat.top_lower) && emit_ok) begin
                            cmd.pop  = 1'b1;
                            cmd.emit = 1'b1;
                        end
                    end
                    REQ_END: begin
                        if (stat.top_is_lp) begin
                            cmd.pop = 1'b1;
                        end else if (emit_ok) begin
                            cmd.pop  = 1'b1;
                            cmd.emit = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_PUSH: begin
                if (stat.full) begin
                    cmd.err_wr  = 1'b1;
                    cmd.err_val = ERR_OVERFLOW;
                end else begin
                    cmd.push = 1'b1;
                end
            end
            ST_FINISH: cmd.finish = stat.out_free;
            default: ;
        endcase
    end

    `ASSERT_SAME(a_emit_room, cmd.emit, !stat.pend_valid || stat.out_free, "emit without room")
    `ASSERT_SAME(a_push_room, cmd.push, !stat.full, "push onto a full stack")
    `ASSERT_NEXT(a_finish_idle, cmd.finish, r_state == ST_IDLE, "finish did not end the item")

endmodule

`default_nettype wire

// ----- hdl/itp_dp.sv -----
`default_nettype none

module itp_dp
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = IPC_STACK_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [31:0] i_number_value,
    input  wire logic [2:0]  i_op_code,
    input  wire logic        i_stall,
    input  wire t_cmd        cmd,
    output t_stat            stat,
    output logic             o_valid,
    output logic [1:0]       o_out_kind,
    output logic [31:0]      o_out_value,
    output logic [2:0]       o_out_op,
    output logic             o_last,
    output logic [1:0]       o_error_code
);

`include "assert_macros.svh"

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);

    logic [2:0]    mem [STACK_DEPTH];
    logic [2:0]    r_rd_data;
    logic [LW-1:0] r_level;

    logic [2:0]    r_kind;
    logic [2:0]    r_op;
    t_err          r_err;

    logic          r_pend_valid;
    t_out_kind     r_pend_kind;
    logic [31:0]   r_pend_value;
    logic [2:0]    r_pend_op;

    logic          r_out_valid;
    t_out_kind     r_out_kind;
    logic [31:0]   r_out_value;
    logic [2:0]    r_out_op;
    logic          r_out_last;
    t_err          r_out_err;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [2:0]    push_code;
    logic          out_free;

    assign rd_addr   = AW'(r_level - LW'(1));
    assign wr_addr   = r_level[AW-1:0];
    assign push_code = (r_kind == REQ_LPAREN) ? LPAREN_MARK : r_op;
    assign out_free  = !r_out_valid || !i_stall;

    // stack memory, registered read of the entry below the level
    always_ff @(posedge i_clk) begin
        if (cmd.push) begin
            mem[wr_addr] <= push_code;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load) begin
            r_kind <= i_req_type;
            r_op   <= i_op_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_err   <= ERR_OK;
        end else begin
            if (cmd.push) begin
                r_level <= r_level + LW'(1);
            end else if (cmd.pop) begin
                r_level <= r_level - LW'(1);
            end
            if (cmd.load) begin
                r_err <= ERR_OK;
            end else if (cmd.err_wr) begin
                r_err <= cmd.err_val;
            end
        end
    end

    // one token held back so the final one can carry last and the error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (cmd.load) begin
            r_pend_valid <= (i_req_type == REQ_NUM);
            r_pend_kind  <= KIND_NUM;
            r_pend_value <= i_number_value;
            r_pend_op    <= '0;
        end else if (cmd.emit) begin
            r_pend_valid <= 1'b1;
            r_pend_kind  <= KIND_OP;
            r_pend_value <= '0;
            r_pend_op    <= r_rd_data;
        end else if (cmd.finish) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit && r_pend_valid) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= r_pend_kind;
            r_out_value <= r_pend_value;
            r_out_op    <= r_pend_op;
            r_out_last  <= 1'b0;
            r_out_err   <= ERR_OK;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= r_pend_valid ? r_pend_kind : KIND_STATUS;
            r_out_value <= r_pend_valid ? r_pend_value : 32'd0;
            r_out_op    <= r_pend_valid ? r_pend_op : 3'd0;
            r_out_last  <= 1'b1;
            r_out_err   <= r_err;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        stat.kind       = r_kind;
        stat.op_ok      = (r_op <= OP_SUB);
        stat.level_zero = (r_level == '0);
        stat.level_one  = (r_level == LW'(1));
        stat.full       = (r_level >= LW'(STACK_DEPTH));
        stat.top_is_lp  = (r_rd_data == LPAREN_MARK);
        stat.top_lower  = !is_mul(r_rd_data) && is_mul(r_op);
        stat.out_free   = out_free;
        stat.pend_valid = r_pend_valid;
    end

    assign o_valid      = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_value  = r_out_value;
    assign o_out_op     = r_out_op;
    assign o_last       = r_out_last;
    assign o_error_code = r_out_err;

    `ASSERT_NEXT(a_pop_dec, cmd.pop, r_level == $past(r_level) - LW'(1), "pop lost the level")
    `ASSERT_NEXT(a_level_hold, !cmd.push && !cmd.pop, $stable(r_level), "level moved on its own")
    `ASSERT_NEXT(a_finish_last, cmd.finish, r_out_valid && r_out_last, "final token not marked")

endmodule

`default_nettype wire

// ----- hdl/infix_to_postfix_converter_unit.sv -----
`default_nettype none

// Infix to postfix converter (shunting yard). Each input item is one infix
// token: a number, a left or right parenthesis, an operator (multiply,
// divide, modulo, add, subtract) or end of expression. Numbers pass straight
// through; operators wait on an operator stack of STACK_DEPTH entries and are
// emitted by precedence, multiplicative above additive, left associative.
// Every item yields at least one output item and the final one has o_last
// set; an item that produces no token yields a single status-only item.
// o_error_code on that final item reports a stack overflow (the token is not
// pushed) or an unmatched right parenthesis (the stack is emptied). A left
// parenthesis still open at end of expression is dropped silently. The block
// handles one item at a time: it accepts the item, dispatches on its kind,
// then, for every stack entry that is examined, reads the stack through its
// registered read port and examines the top, whether the entry is popped or
// is the entry that stops the pop loop. A push, or a push refused by a full
// stack, takes its own push step, and a final step sends the last output
// item. The output register and one held-back token decouple the two sides.
// An emit waits only while both of them are occupied and the downstream
// stalls. The last output item of an item waits until the output register
// is free.

module infix_to_postfix_converter_unit
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = IPC_STACK_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [31:0] i_number_value,
    input  wire logic [2:0]  i_op_code,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_out_kind,
    output logic [31:0]      o_out_value,
    output logic [2:0]       o_out_op,
    output logic             o_last,
    output logic [1:0]       o_error_code
);

    // commands from the sequencer, status back from the stack datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: dispatch, pop loop, push and final output
    itp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .stat    (stat),
        .cmd     (cmd)
    );

    // operator stack, held-back token and output register
    itp_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_number_value (i_number_value),
        .i_op_code      (i_op_code),
        .i_stall        (i_stall),
        .cmd            (cmd),
        .stat           (stat),
        .o_valid        (o_valid),
        .o_out_kind     (o_out_kind),
        .o_out_value    (o_out_value),
        .o_out_op       (o_out_op),
        .o_last         (o_last),
        .o_error_code   (o_error_code)
    );

endmodule

`default_nettype wire
